// ===== hw/rtl/lfust_pkg.sv =====
// package for the lfu slot table: field widths, scan word and write command types
// used by lfust_cell and lfu_slot_table_fifo_tiebreak; depends on nothing
`default_nettype none

package lfust_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int SLOTS_MAX = 256;
    localparam int IDX_W     = $clog2(SLOTS_MAX);
    localparam int ID_W      = 16;
    localparam int USE_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 6;
    localparam int SLOT_W    = 5;

    localparam logic [USE_W-1:0] USE_MAX = '1;
    localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(32);

    // scan word handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic              found;
        logic              hit;
        logic [IDX_W-1:0]  pick;
        logic [IDX_W-1:0]  best_idx;
        logic [USE_W-1:0]  best_uses;
        logic [TIME_W-1:0] best_birth;
        logic [ID_W-1:0]   best_tag;
    } t_scan;

    // write-back command broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              inc;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   tag;
        logic [TIME_W-1:0] birth;
    } t_wr;

endpackage

`default_nettype wire

// ===== hw/rtl/lfust_cell.sv =====
// one slot of the table: valid, tag, use count, birth time, plus one stage of the scan chain
// depends on lfust_pkg
`default_nettype none

module lfust_cell #(
    parameter int SLOTS    = lfust_pkg::SLOTS_DEF,
    parameter int CELL_IDX = 0,
    localparam int CW      = $clog2(SLOTS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CW-1:0]    i_live,
    input  wire lfust_pkg::t_scan i_scan,
    output lfust_pkg::t_scan      o_scan,
    input  wire lfust_pkg::t_wr   i_wr
);

    localparam logic [lfust_pkg::IDX_W-1:0] MY_IDX = lfust_pkg::IDX_W'(CELL_IDX);

    logic                          r_valid, n_valid;
    logic [lfust_pkg::ID_W-1:0]    r_tag, n_tag;
    logic [lfust_pkg::USE_W-1:0]   r_uses, n_uses;
    logic [lfust_pkg::TIME_W-1:0]  r_birth, n_birth;
    lfust_pkg::t_scan              r_scan, n_scan;

    logic w_active;
    logic w_sel;
    logic w_better;

    assign w_active = (CW'(CELL_IDX) < i_live);
    assign w_sel    = i_wr.en && (i_wr.idx == MY_IDX);
    assign w_better = (CELL_IDX == 0) || (r_uses < i_scan.best_uses) ||
                      ((r_uses == i_scan.best_uses) && (r_birth < i_scan.best_birth));

    always_comb begin
        n_scan = i_scan;
        if (i_scan.vld && w_active && !i_scan.found) begin
            if (!r_valid) begin
                n_scan.found = 1'b1;
                n_scan.hit   = 1'b0;
                n_scan.pick  = MY_IDX;
            end else begin
                if (r_tag == i_scan.id) begin
                    n_scan.found = 1'b1;
                    n_scan.hit   = 1'b1;
                    n_scan.pick  = MY_IDX;
                end
                // least count, then earliest birth; strict compare keeps the lower index
                if (w_better) begin
                    n_scan.best_idx   = MY_IDX;
                    n_scan.best_uses  = r_uses;
                    n_scan.best_birth = r_birth;
                    n_scan.best_tag   = r_tag;
                end
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_uses  = r_uses;
        n_birth = r_birth;
        if (w_sel) begin
            if (i_wr.inc) begin
                if (r_uses != lfust_pkg::USE_MAX) begin
                    n_uses = r_uses + lfust_pkg::USE_W'(1);
                end
            end else begin
                n_valid = 1'b1;
                n_tag   = i_wr.tag;
                n_uses  = lfust_pkg::USE_W'(1);
                n_birth = i_wr.birth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_scan.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_uses  <= n_uses;
        r_birth <= n_birth;
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_slot_table_fifo_tiebreak.sv =====
// top level of the lfu slot table with fifo tie-break: control, scan chain of cells, result register
// depends on lfust_pkg and lfust_cell
//
//  channel   direction  handshake                  word
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_active_slots
//  in        in         i_in_valid  / o_in_ready   i_candidate_id
//  out       out        o_out_valid / i_out_ready  o_hit, o_slot, o_evicted_valid, o_evicted_id
//
// from acceptance the scan word is registered into the start register, then walks the cell
// chain one slot per cycle; the decision stage then registers the result and the write-back
// one word is in the table at a time; a new word is taken once the previous result
// has moved into the output register, which may still wait for i_out_ready
// a stalled output holds the finished word in the decision stage
// synchronous active-low reset empties all slots and zeroes the arrival count
`default_nettype none

module lfu_slot_table_fifo_tiebreak #(
    parameter int SLOTS = lfust_pkg::SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lfust_pkg::CFG_W-1:0]    i_cfg_active_slots,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [lfust_pkg::ID_W-1:0]     i_candidate_id,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_hit,
    output logic [lfust_pkg::SLOT_W-1:0]        o_slot,
    output logic                                o_evicted_valid,
    output logic [lfust_pkg::ID_W-1:0]          o_evicted_id
);

    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [lfust_pkg::CFG_W-1:0]     r_active;
    logic [CW-1:0]                   w_live;
    logic [lfust_pkg::TIME_W-1:0]    r_arrival;
    logic [lfust_pkg::TIME_W-1:0]    r_now;
    lfust_pkg::t_scan                r_start, n_start;
    lfust_pkg::t_wr                  r_wr, n_wr;
    lfust_pkg::t_scan                w_chain [SLOTS+1];
    logic [SLOTS:0]                  w_vlds;

    logic                            r_res_hit, n_res_hit;
    logic [lfust_pkg::IDX_W-1:0]     r_res_idx, n_res_idx;
    logic                            r_res_ev, n_res_ev;
    logic [lfust_pkg::ID_W-1:0]      r_res_evid, n_res_evid;

    logic w_in_acc;
    logic w_out_load;
    lfust_pkg::t_scan w_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == ST_DONE) && (!o_out_valid || i_out_ready);
    assign w_last      = w_chain[SLOTS];

    // zero acts as one, anything above the built depth acts as the depth
    always_comb begin
        if (r_active == '0) begin
            w_live = CW'(1);
        end else if (32'(r_active) > SLOTS) begin
            w_live = CW'(SLOTS);
        end else begin
            w_live = CW'(r_active);
        end
    end

    always_comb begin
        n_start      = '0;
        n_start.vld  = w_in_acc;
        n_start.id   = i_candidate_id;
    end

    assign w_chain[0] = r_start;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lfust_cell #(
            .SLOTS    (SLOTS),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_live  (w_live),
            .i_scan  (w_chain[g]),
            .o_scan  (w_chain[g+1]),
            .i_wr    (r_wr)
        );
    end

    for (genvar v = 0; v <= SLOTS; v++) begin : g_vld
        assign w_vlds[v] = w_chain[v].vld;
    end

    // decision at the end of the chain
    always_comb begin
        n_wr       = r_wr;
        n_wr.en    = 1'b0;
        n_res_hit  = r_res_hit;
        n_res_idx  = r_res_idx;
        n_res_ev   = r_res_ev;
        n_res_evid = r_res_evid;
        if (w_last.vld) begin
            n_wr.en    = 1'b1;
            n_wr.tag   = w_last.id;
            n_wr.birth = r_now;
            if (w_last.found) begin
                n_wr.inc   = w_last.hit;
                n_wr.idx   = w_last.pick;
                n_res_hit  = w_last.hit;
                n_res_idx  = w_last.pick;
                n_res_ev   = 1'b0;
                n_res_evid = '0;
            end else begin
                n_wr.inc   = 1'b0;
                n_wr.idx   = w_last.best_idx;
                n_res_hit  = 1'b0;
                n_res_idx  = w_last.best_idx;
                n_res_ev   = 1'b1;
                n_res_evid = w_last.best_tag;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last.vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= lfust_pkg::ACTIVE_RST;
            r_arrival   <= '0;
            r_start.vld <= 1'b0;
            r_wr.en     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_active_slots;
            end
            if (w_in_acc) begin
                r_arrival <= r_arrival + lfust_pkg::TIME_W'(1);
            end
            r_start <= n_start;
            r_wr    <= n_wr;
            if (w_out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now <= r_arrival;
        end
        r_res_hit  <= n_res_hit;
        r_res_idx  <= n_res_idx;
        r_res_ev   <= n_res_ev;
        r_res_evid <= n_res_evid;
        if (w_out_load) begin
            o_hit           <= r_res_hit;
            o_slot          <= r_res_idx[lfust_pkg::SLOT_W-1:0];
            o_evicted_valid <= r_res_ev;
            o_evicted_id    <= r_res_evid;
        end
    end

    // at most one scan word anywhere in the chain
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vlds))
        else $error("more than one scan word in the cell chain");

    // the chain only delivers while the controller waits for it
    a_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.vld |-> (r_state == ST_SCAN))
        else $error("scan word left the chain outside the scan state");

    // write-back is a single pulse per word
    a_wr_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.en |=> !r_wr.en)
        else $error("write-back held for more than one cycle");

    // an eviction is never reported as a hit
    a_ev_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted_valid) |-> !o_hit)
        else $error("eviction reported together with a hit");

endmodule

`default_nettype wire
